/* rtl/core/bts_pkg.sv */
// shared types and constants of the buzzer tone sequencer
// used by the top level and by the result queue; depends on nothing
`timescale 1ns / 1ps

package bts_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic buzzer_level;
      logic is_playing;
      logic song_done;
   } rsp_type;

   localparam logic [15:0] TONE_MAX = 16'hFFFF;

endpackage

/* rtl/core/bts_rsp_fifo.sv */
// two-entry result queue between the sequencer core and the rsp_ channel
// depends on bts_pkg for the result type
`timescale 1ns / 1ps

module bts_rsp_fifo
   import bts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rsp_type push_data,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop_ready,
   output rsp_type pop_data
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       pop;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push_valid, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/buzzer_tone_sequencer.sv */
// top level of the buzzer tone sequencer: song memory, tone timer, result queue
// depends on bts_pkg and bts_rsp_fifo
`timescale 1ns / 1ps

// The block takes one request per clock while req_ready is high (table write,
// start, timer tick or no-op) and answers each with one result: buzzer level,
// playing and done flags as they stand after that request. Each result goes
// into a two-entry queue for rsp_ when its request is transferred, so req_ready
// drops only when two results are waiting. The song table sits in one memory
// with a registered read; the block keeps the pitch of the playing entry and the
// following entry in registers and refetches the entry after that on every note
// change, so notes may change on consecutive ticks. No clearing pass runs after reset.

module buzzer_tone_sequencer
   import bts_pkg::*;
#(
   parameter int TABLE_DEPTH   = 256,
   parameter int SPEED_DIVISOR = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_entry_index,
   input  logic [15:0] req_reload_value,
   input  logic [15:0] req_note_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_buzzer_level,
   output logic        rsp_is_playing,
   output logic        rsp_song_done
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IW-1:0] LAST_ENTRY = IW'(TABLE_DEPTH - 1);
   localparam logic [19:0] DEPTH_W = 20'(TABLE_DEPTH);
   // reciprocal of the speed factor, exact for every 16-bit length at the default divisor of 2
   localparam int RECIP = ((2 ** 17) + SPEED_DIVISOR - 1) / SPEED_DIVISOR;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] e);
      wrap_inc = (e == LAST_ENTRY) ? '0 : (e + IW'(1));
   endfunction

   // write address modulo the table depth by restoring subtraction
   function automatic logic [IW-1:0] mod_depth(input logic [7:0] v);
      logic [19:0] r;
      r = {12'd0, v};
      for (int k = 7; k >= 0; k--) begin
         if (r >= (DEPTH_W << k)) begin
            r = r - (DEPTH_W << k);
         end
      end
      mod_depth = r[IW-1:0];
   endfunction

   logic [31:0]   song_mem [TABLE_DEPTH];
   logic [31:0]   rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_idx;

   logic [15:0]   tone_ff, tone_in;
   logic [15:0]   remain_ff, remain_in;
   logic [IW-1:0] entry_ff, entry_in;
   logic          buzz_ff, buzz_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [15:0]   cur_pitch_ff, cur_pitch_in;
   logic [15:0]   nxt_pitch_ff, nxt_pitch_in;
   logic [15:0]   nxt_len_ff, nxt_len_in;
   logic [15:0]   z_pitch_ff, z_pitch_in;
   logic [15:0]   z_len_ff, z_len_in;
   logic          pend_ff, pend_in;

   logic          acc;
   opcode_type    op;
   logic [IW-1:0] entry_plus1;
   logic [IW-1:0] entry_plus2;
   logic [15:0]   eff_pitch;
   logic [15:0]   eff_len;
   logic [15:0]   ld_pitch;
   logic [15:0]   ld_len;
   logic [33:0]   ld_prod;
   logic [15:0]   ld_halves;
   logic          ld_term;
   logic          do_load;
   logic [15:0]   rem_dec;
   logic          q_full;
   rsp_type       push_data;
   rsp_type       pop_data;

   assign acc         = req_valid && req_ready;
   assign op          = opcode_type'(req_opcode);
   assign wr_idx      = mod_depth(req_entry_index);
   assign entry_plus1 = wrap_inc(entry_ff);
   assign entry_plus2 = wrap_inc(entry_plus1);

   // the entry after the playing one arrives from memory in the cycle after a note change
   assign eff_pitch = pend_ff ? rd_data_ff[31:16] : nxt_pitch_ff;
   assign eff_len   = pend_ff ? rd_data_ff[15:0]  : nxt_len_ff;

   assign ld_pitch  = (op == OP_START) ? z_pitch_ff : eff_pitch;
   assign ld_len    = (op == OP_START) ? z_len_ff   : eff_len;
   assign ld_term   = (ld_pitch == 16'd0) && (ld_len == 16'd0);
   assign ld_prod   = {18'd0, ld_len} * 34'(RECIP);
   assign ld_halves = (ld_prod[32:17] == 16'd0) ? 16'd1 : ld_prod[32:17];
   assign rem_dec   = remain_ff - 16'd1;

   always_comb begin
      tone_in      = tone_ff;
      remain_in    = remain_ff;
      entry_in     = entry_ff;
      buzz_in      = buzz_ff;
      run_in       = run_ff;
      done_in      = done_ff;
      cur_pitch_in = cur_pitch_ff;
      nxt_pitch_in = eff_pitch;
      nxt_len_in   = eff_len;
      z_pitch_in   = z_pitch_ff;
      z_len_in     = z_len_ff;
      pend_in      = 1'b0;
      rd_addr      = entry_plus2;
      wr_en        = 1'b0;
      do_load      = 1'b0;

      if (acc) begin
         unique case (op)
            OP_WRITE: begin
               wr_en = 1'b1;
               if (wr_idx == entry_ff) begin
                  cur_pitch_in = req_reload_value;
               end
               if (wr_idx == entry_plus1) begin
                  nxt_pitch_in = req_reload_value;
                  nxt_len_in   = req_note_length;
               end
               if (wr_idx == '0) begin
                  z_pitch_in = req_reload_value;
                  z_len_in   = req_note_length;
               end
            end
            OP_START: begin
               done_in  = 1'b0;
               entry_in = '0;
               do_load  = 1'b1;
               rd_addr  = IW'(1);
            end
            OP_TICK: begin
               if (run_ff) begin
                  if (tone_ff == TONE_MAX) begin
                     tone_in   = cur_pitch_ff;
                     buzz_in   = ~buzz_ff;
                     remain_in = rem_dec;
                     if (rem_dec == 16'd0) begin
                        entry_in = entry_plus1;
                        do_load  = 1'b1;
                     end
                  end else begin
                     tone_in = tone_ff + 16'd1;
                  end
               end
            end
            OP_NONE: begin
            end
         endcase
      end

      if (do_load) begin
         pend_in      = 1'b1;
         cur_pitch_in = ld_pitch;
         if (ld_term) begin
            done_in = 1'b1;
            run_in  = 1'b0;
            buzz_in = 1'b1;
         end else begin
            tone_in   = ld_pitch;
            remain_in = ld_halves;
            run_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         song_mem[wr_idx] <= {req_reload_value, req_note_length};
      end
      rd_data_ff <= song_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff   <= 16'd0;
         remain_ff <= 16'd0;
         entry_ff  <= '0;
         buzz_ff   <= 1'b1;
         run_ff    <= 1'b0;
         done_ff   <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         tone_ff   <= tone_in;
         remain_ff <= remain_in;
         entry_ff  <= entry_in;
         buzz_ff   <= buzz_in;
         run_ff    <= run_in;
         done_ff   <= done_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_pitch_ff <= cur_pitch_in;
      nxt_pitch_ff <= nxt_pitch_in;
      nxt_len_ff   <= nxt_len_in;
      z_pitch_ff   <= z_pitch_in;
      z_len_ff     <= z_len_in;
   end

   assign push_data.buzzer_level = buzz_in;
   assign push_data.is_playing   = run_in;
   assign push_data.song_done    = done_in;

   bts_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (acc),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (pop_data)
   );

   assign req_ready        = ~q_full;
   assign rsp_buzzer_level = pop_data.buzzer_level;
   assign rsp_is_playing   = pop_data.is_playing;
   assign rsp_song_done    = pop_data.song_done;

endmodule

/* rtl/core/bts_checker.sv */
// port-level checks of the buzzer tone sequencer and their bind to the top level
// depends on the port names of buzzer_tone_sequencer
`timescale 1ns / 1ps

module bts_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_buzzer_level,
   input logic rsp_is_playing,
   input logic rsp_song_done
);

   // a stalled result transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_buzzer_level)
         && $stable(rsp_is_playing) && $stable(rsp_song_done))
      else $error("result changed while stalled");

   // queue is empty after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // playing and done exclude each other
   a_play_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_playing && rsp_song_done))
      else $error("playing and done both set");

   // buzzer is silent whenever no song plays
   a_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_playing |-> rsp_buzzer_level)
      else $error("buzzer driven while stopped");

   // with no result waiting the block takes requests
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty queue");

endmodule

bind buzzer_tone_sequencer bts_checker u_bts_checker (.*);

/* tb/buzzer_tone_sequencer_tb.sv */
// self-checking testbench for buzzer_tone_sequencer: directed note cases, then random songs
// depends on bts_pkg and the buzzer_tone_sequencer rtl
`timescale 1ns / 1ps

module buzzer_tone_sequencer_tb;
   import bts_pkg::*;

   localparam int TABLE_DEPTH   = 256;
   localparam int SPEED_DIVISOR = 2;
   localparam int MAX_SHOWN     = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_NONE;
   logic [7:0]  req_entry_index = 8'd0;
   logic [15:0] req_reload_value = 16'd0;
   logic [15:0] req_note_length = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_buzzer_level;
   logic        rsp_is_playing;
   logic        rsp_song_done;

   // predicted sequencer state
   logic [15:0] pitch_mem [TABLE_DEPTH];
   logic [15:0] length_mem [TABLE_DEPTH];
   logic [15:0] tone_cnt = 16'd0;
   logic [15:0] halves_left = 16'd0;
   logic [7:0]  note_ptr = 8'd0;
   logic        buzz_level = 1'b1;
   logic        playing = 1'b0;
   logic        song_over = 1'b0;

   rsp_type expected_status_q [$];
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int transfers_sent = 0;
   int mismatch_count = 0;

   buzzer_tone_sequencer #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .SPEED_DIVISOR(SPEED_DIVISOR)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_entry_index(req_entry_index),
      .req_reload_value(req_reload_value),
      .req_note_length(req_note_length),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_buzzer_level(rsp_buzzer_level),
      .rsp_is_playing(rsp_is_playing),
      .rsp_song_done(rsp_song_done)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic load_note();
      logic [15:0] halves;
      if (pitch_mem[note_ptr] == 16'd0 && length_mem[note_ptr] == 16'd0) begin
         // terminator entry
         song_over = 1'b1;
         playing = 1'b0;
         buzz_level = 1'b1;
      end else begin
         tone_cnt = pitch_mem[note_ptr];
         halves = length_mem[note_ptr] / 16'(SPEED_DIVISOR);
         if (halves == 16'd0) halves = 16'd1;
         halves_left = halves;
         playing = 1'b1;
      end
   endtask

   task automatic predict_status(opcode_type op, logic [7:0] idx, logic [15:0] pitch,
                                 logic [15:0] len);
      rsp_type status;
      case (op)
         OP_WRITE: begin
            pitch_mem[idx % TABLE_DEPTH] = pitch;
            length_mem[idx % TABLE_DEPTH] = len;
         end
         OP_START: begin
            song_over = 1'b0;
            note_ptr = 8'd0;
            load_note();
         end
         OP_TICK: begin
            if (playing) begin
               if (tone_cnt == TONE_MAX) begin
                  tone_cnt = pitch_mem[note_ptr];
                  buzz_level = ~buzz_level;
                  halves_left = halves_left - 16'd1;
                  if (halves_left == 16'd0) begin
                     note_ptr = note_ptr + 8'd1;
                     load_note();
                  end
               end else begin
                  tone_cnt = tone_cnt + 16'd1;
               end
            end
         end
         default: ;
      endcase
      status.buzzer_level = buzz_level;
      status.is_playing = playing;
      status.song_done = song_over;
      expected_status_q.push_back(status);
   endtask

   task automatic send_request(opcode_type op, logic [7:0] idx, logic [15:0] pitch,
                               logic [15:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_entry_index <= idx;
      req_reload_value <= pitch;
      req_note_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_status(op, idx, pitch, len);
      transfers_sent++;
   endtask

   task automatic write_entry(logic [7:0] idx, logic [15:0] pitch, logic [15:0] len);
      send_request(OP_WRITE, idx, pitch, len);
   endtask

   // unused fields carry random junk
   task automatic send_command(opcode_type op);
      send_request(op, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_buzzer_level, rsp_is_playing, rsp_song_done};
         if (expected_status_q.size() == 0) begin
            if (mismatch_count < MAX_SHOWN)
               $display("%0t: transfer on rsp with nothing expected: %b", $time, got);
            mismatch_count++;
         end else begin
            want = expected_status_q.pop_front();
            if (got.buzzer_level !== want.buzzer_level || got.is_playing !== want.is_playing ||
                got.song_done !== want.song_done) begin
               if (mismatch_count < MAX_SHOWN)
                  $display("%0t: mismatch: expected buzzer %b playing %b done %b, got %b %b %b",
                           $time, want.buzzer_level, want.is_playing, want.song_done,
                           got.buzzer_level, got.is_playing, got.song_done);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_stopped_state();
      send_command(OP_NONE);
      send_command(OP_TICK);
   endtask

   // every entry a one-tick note, so the playing index runs past the last entry
   task automatic test_entry_wrap();
      for (int i = 0; i < TABLE_DEPTH; i++) write_entry(8'(i), 16'hFFFF, 16'h0001);
      send_command(OP_START);
      repeat (TABLE_DEPTH + 5) send_command(OP_TICK);
      write_entry(8'd0, 16'd0, 16'd0);
      send_command(OP_START);
      send_command(OP_TICK);
   endtask

   task automatic test_note_special_cases();
      write_entry(8'd255, 16'hFFFF, 16'hFFFF);
      write_entry(8'd254, 16'h0000, 16'hFFFF);
      write_entry(8'd253, 16'hFFFF, 16'h0000);
      write_entry(8'd0, 16'hFFFE, 16'h0000);
      write_entry(8'd1, 16'hFFFD, 16'h0005);
      write_entry(8'd2, 16'h0000, 16'h0000);
      send_command(OP_START);
      repeat (2) send_command(OP_TICK);
      // restart in the middle of a song keeps the buzzer level
      send_command(OP_START);
      repeat (2) send_command(OP_TICK);
      // new pitch for the playing note only shows after its next reload
      write_entry(8'd1, 16'hFFFF, 16'h0005);
      repeat (5) send_command(OP_TICK);
      send_command(OP_NONE);
      send_command(OP_START);
   endtask

   task automatic test_random_playback(int idle_pct, int stall_pct, int n_items);
      int stop_at;
      int n_notes;
      int n_ticks;
      int pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at = transfers_sent + n_items;
      while (transfers_sent < stop_at) begin
         n_notes = $urandom_range(1, 6);
         for (int i = 0; i < n_notes; i++)
            write_entry(8'(i), 16'hFFFF - 16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)));
         write_entry(8'(n_notes), 16'd0, 16'd0);
         if ($urandom_range(9) != 0) send_command(OP_START);
         n_ticks = $urandom_range(10, 150);
         repeat (n_ticks) begin
            pick = $urandom_range(99);
            if (pick < 86) send_command(OP_TICK);
            else if (pick < 91) write_entry(8'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 95) send_command(OP_NONE);
            else send_command(OP_START);
         end
      end
      drain_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_stopped_state();
      test_entry_wrap();
      test_note_special_cases();
      drain_results();
      test_random_playback(0, 0, 260);
      test_random_playback(57, 0, 260);
      test_random_playback(0, 57, 260);
      test_random_playback(37, 37, 260);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_status_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
